// ===== rtl/ile_pkg.sv =====
// ----------------------------------------------------------------------------
// ile_pkg
// Shared codes, widths and types for the indexed list engine.
// ----------------------------------------------------------------------------
`default_nettype none

package ile_pkg;

    localparam int VAL_W  = 32;
    localparam int FUNC_W = 3;
    localparam int STAT_W = 2;

    localparam logic [FUNC_W-1:0] F_APPEND  = 3'd0;
    localparam logic [FUNC_W-1:0] F_INSERT  = 3'd1;
    localparam logic [FUNC_W-1:0] F_POP     = 3'd2;
    localparam logic [FUNC_W-1:0] F_REMOVE  = 3'd3;
    localparam logic [FUNC_W-1:0] F_READ    = 3'd4;
    localparam logic [FUNC_W-1:0] F_REVERSE = 3'd5;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd3;

    typedef struct packed {
        logic lt;
        logic eq;
    } t_cmp_flags;

endpackage

`default_nettype wire

// ===== rtl/ile_ram.sv =====
// ----------------------------------------------------------------------------
// ile_ram
// List storage: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ile_ram #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  wire                      i_clk,
    input  wire                      i_we,
    input  wire  [AW-1:0]            i_wa,
    input  wire  [ile_pkg::VAL_W-1:0] i_wd,
    input  wire  [AW-1:0]            i_ra,
    output logic [ile_pkg::VAL_W-1:0] o_rd
);
    import ile_pkg::*;

    logic [VAL_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wa] <= i_wd;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rd <= r_mem[i_ra];
    end

endmodule

`default_nettype wire

// ===== rtl/ile_step_unit.sv =====
// ----------------------------------------------------------------------------
// ile_step_unit
// Shared index unit: increment or decrement of one operand, and a compare
// of that operand against a bound.
// ----------------------------------------------------------------------------
`default_nettype none

module ile_step_unit #(
    parameter int W = 7
) (
    input  wire  [W-1:0]              i_a,
    input  wire  [W-1:0]              i_b,
    input  wire                       i_dec,
    output logic [W-1:0]              o_nxt,
    output ile_pkg::t_cmp_flags       o_flags
);
    import ile_pkg::*;

    always_comb begin
        o_nxt      = i_dec ? (i_a - W'(1)) : (i_a + W'(1));
        o_flags.lt = (i_a < i_b);
        o_flags.eq = (i_a == i_b);
    end

endmodule

`default_nettype wire

// ===== rtl/indexed_list_engine_core.sv =====
// ----------------------------------------------------------------------------
// indexed_list_engine_core
// Ordered list of signed 32-bit values with positional insert and remove.
// One request item enters on the s_axis side: the operation code in tuser,
// the position and the value in tdata. One result item leaves on the m_axis
// side for every request: the status in tuser, the read value and the new
// length in tdata. The block takes one request at a time and can accept the
// next one in the cycle in which the result appears; s_axis_tready is high
// while the sequencer is idle, also while a result still waits.
// Insert moves each entry from the position up by one place, remove moves each
// entry above the position down by one place, and reverse swaps pairs from both
// ends inward; each step goes through the single memory read port and the
// shared index unit.
// Reset empties the list at once; the stored words are not cleared. A stalled
// receiver holds the finished result in the output register, and the
// sequencer waits before its next result.
// ----------------------------------------------------------------------------
`default_nettype none

module indexed_list_engine_core #(
    parameter int CAPACITY = 64
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                s_axis_tvalid,
    output logic                               s_axis_tready,
    // position, new_value, zero pad
    input  wire  [((($clog2(CAPACITY+1))+32+7)/8)*8-1:0] s_axis_tdata,
    // func
    input  wire  [ile_pkg::FUNC_W-1:0]         s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  wire                                m_axis_tready,
    // read_value, length, zero pad
    output logic [((($clog2(CAPACITY+1))+32+7)/8)*8-1:0] m_axis_tdata,
    // status
    output logic [ile_pkg::STAT_W-1:0]         m_axis_tuser
);
    import ile_pkg::*;

    localparam int CW     = $clog2(CAPACITY + 1);
    localparam int AW     = $clog2(CAPACITY);
    localparam int DW     = ((CW + VAL_W + 7) / 8) * 8;
    localparam int PAD_W  = DW - CW - VAL_W;
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    localparam logic [4:0] S_IDLE      = 5'd0;
    localparam logic [4:0] S_DECODE    = 5'd1;
    localparam logic [4:0] S_INS_RD    = 5'd2;
    localparam logic [4:0] S_INS_WR    = 5'd3;
    localparam logic [4:0] S_INS_PUT   = 5'd4;
    localparam logic [4:0] S_RD_WAIT   = 5'd5;
    localparam logic [4:0] S_REM_START = 5'd6;
    localparam logic [4:0] S_REM_CHK   = 5'd7;
    localparam logic [4:0] S_REM_RD    = 5'd8;
    localparam logic [4:0] S_REM_WR    = 5'd9;
    localparam logic [4:0] S_REV_START = 5'd10;
    localparam logic [4:0] S_REV_CHK   = 5'd11;
    localparam logic [4:0] S_REV_RA    = 5'd12;
    localparam logic [4:0] S_REV_RB    = 5'd13;
    localparam logic [4:0] S_REV_WA    = 5'd14;
    localparam logic [4:0] S_REV_WB    = 5'd15;
    localparam logic [4:0] S_DONE      = 5'd16;

    logic [4:0]        r_state,   n_state;
    logic [FUNC_W-1:0] r_func,    n_func;
    logic [CW-1:0]     r_pos,     n_pos;
    logic [VAL_W-1:0]  r_val,     n_val;
    logic [CW-1:0]     r_count,   n_count;
    logic [CW-1:0]     r_idx,     n_idx;
    logic [CW-1:0]     r_wa,      n_wa;
    logic [CW-1:0]     r_hi,      n_hi;
    logic [VAL_W-1:0]  r_hold,    n_hold;
    logic [STAT_W-1:0] r_status,  n_status;
    logic [VAL_W-1:0]  r_rd,      n_rd;
    logic              r_ovalid,  n_ovalid;
    logic [STAT_W-1:0] r_ostatus, n_ostatus;
    logic [VAL_W-1:0]  r_ord,     n_ord;
    logic [CW-1:0]     r_olen,    n_olen;

    logic [CW-1:0]     u_a;
    logic [CW-1:0]     u_b;
    logic              u_dec;
    logic [CW-1:0]     u_nxt;
    t_cmp_flags        u_flags;

    logic              mem_we;
    logic [CW-1:0]     mem_wa;
    logic [VAL_W-1:0]  mem_wd;
    logic [CW-1:0]     mem_ra;
    logic [VAL_W-1:0]  mem_rd;

    logic              empty;
    logic              full;

    ile_step_unit #(
        .W (CW)
    ) u_step (
        .i_a     (u_a),
        .i_b     (u_b),
        .i_dec   (u_dec),
        .o_nxt   (u_nxt),
        .o_flags (u_flags)
    );

    ile_ram #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_ram (
        .i_clk (i_clk),
        .i_we  (mem_we),
        .i_wa  (mem_wa[AW-1:0]),
        .i_wd  (mem_wd),
        .i_ra  (mem_ra[AW-1:0]),
        .o_rd  (mem_rd)
    );

    assign empty = (r_count == '0);
    assign full  = (r_count == CAP_C);

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tuser  = r_ostatus;
    assign m_axis_tdata  = {{PAD_W{1'b0}}, r_olen, r_ord};

    always_comb begin
        n_state   = r_state;
        n_func    = r_func;
        n_pos     = r_pos;
        n_val     = r_val;
        n_count   = r_count;
        n_idx     = r_idx;
        n_wa      = r_wa;
        n_hi      = r_hi;
        n_hold    = r_hold;
        n_status  = r_status;
        n_rd      = r_rd;
        n_ovalid  = r_ovalid;
        n_ostatus = r_ostatus;
        n_ord     = r_ord;
        n_olen    = r_olen;
        u_a       = r_pos;
        u_b       = r_count;
        u_dec     = 1'b0;
        mem_we    = 1'b0;
        mem_wa    = r_count;
        mem_wd    = r_val;
        mem_ra    = r_idx;

        if (r_ovalid && m_axis_tready) begin
            n_ovalid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_func  = s_axis_tuser;
                    n_pos   = s_axis_tdata[CW-1:0];
                    n_val   = s_axis_tdata[CW +: VAL_W];
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                n_status = ST_OK;
                n_rd     = '0;
                n_state  = S_DONE;
                unique case (r_func)
                    F_APPEND: begin
                        u_a = r_count;
                        if (full) begin
                            n_status = ST_FULL;
                        end else begin
                            mem_we  = 1'b1;
                            mem_wa  = r_count;
                            mem_wd  = r_val;
                            n_count = u_nxt;
                        end
                    end
                    F_INSERT: begin
                        if (!(u_flags.lt || u_flags.eq)) begin
                            n_status = ST_RANGE;
                        end else if (full) begin
                            n_status = ST_FULL;
                        end else begin
                            n_idx   = r_count;
                            n_state = u_flags.eq ? S_INS_PUT : S_INS_RD;
                        end
                    end
                    F_POP: begin
                        u_a   = r_count;
                        u_dec = 1'b1;
                        if (empty) begin
                            n_status = ST_EMPTY;
                        end else begin
                            n_count = u_nxt;
                            mem_ra  = u_nxt;
                            n_state = S_RD_WAIT;
                        end
                    end
                    F_REMOVE: begin
                        if (empty) begin
                            n_status = ST_EMPTY;
                        end else if (!u_flags.lt) begin
                            n_status = ST_RANGE;
                        end else begin
                            n_idx   = r_pos;
                            n_state = S_REM_START;
                        end
                    end
                    F_READ: begin
                        if (empty) begin
                            n_status = ST_EMPTY;
                        end else if (!u_flags.lt) begin
                            n_status = ST_RANGE;
                        end else begin
                            mem_ra  = r_pos;
                            n_state = S_RD_WAIT;
                        end
                    end
                    F_REVERSE: begin
                        if (!empty) begin
                            n_idx   = '0;
                            n_state = S_REV_START;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_INS_RD: begin
                u_a     = r_idx;
                u_dec   = 1'b1;
                mem_ra  = u_nxt;
                n_wa    = r_idx;
                n_idx   = u_nxt;
                n_state = S_INS_WR;
            end
            S_INS_WR: begin
                mem_we  = 1'b1;
                mem_wa  = r_wa;
                mem_wd  = mem_rd;
                u_a     = r_idx;
                u_b     = r_pos;
                n_state = u_flags.eq ? S_INS_PUT : S_INS_RD;
            end
            S_INS_PUT: begin
                mem_we  = 1'b1;
                mem_wa  = r_pos;
                mem_wd  = r_val;
                u_a     = r_count;
                n_count = u_nxt;
                n_state = S_DONE;
            end
            S_RD_WAIT: begin
                n_rd    = mem_rd;
                n_state = S_DONE;
            end
            S_REM_START: begin
                u_a     = r_count;
                u_dec   = 1'b1;
                n_count = u_nxt;
                n_state = S_REM_CHK;
            end
            S_REM_CHK: begin
                u_a     = r_idx;
                u_b     = r_count;
                n_state = u_flags.lt ? S_REM_RD : S_DONE;
            end
            S_REM_RD: begin
                u_a     = r_idx;
                mem_ra  = u_nxt;
                n_wa    = r_idx;
                n_idx   = u_nxt;
                n_state = S_REM_WR;
            end
            S_REM_WR: begin
                mem_we  = 1'b1;
                mem_wa  = r_wa;
                mem_wd  = mem_rd;
                u_a     = r_idx;
                u_b     = r_count;
                n_state = u_flags.lt ? S_REM_RD : S_DONE;
            end
            S_REV_START: begin
                u_a     = r_count;
                u_dec   = 1'b1;
                n_hi    = u_nxt;
                n_state = S_REV_CHK;
            end
            S_REV_CHK: begin
                u_a     = r_idx;
                u_b     = r_hi;
                n_state = u_flags.lt ? S_REV_RA : S_DONE;
            end
            S_REV_RA: begin
                mem_ra  = r_idx;
                n_state = S_REV_RB;
            end
            S_REV_RB: begin
                mem_ra  = r_hi;
                n_hold  = mem_rd;
                n_state = S_REV_WA;
            end
            S_REV_WA: begin
                mem_we  = 1'b1;
                mem_wa  = r_idx;
                mem_wd  = mem_rd;
                u_a     = r_idx;
                n_idx   = u_nxt;
                n_state = S_REV_WB;
            end
            S_REV_WB: begin
                mem_we  = 1'b1;
                mem_wa  = r_hi;
                mem_wd  = r_hold;
                u_a     = r_hi;
                u_dec   = 1'b1;
                n_hi    = u_nxt;
                n_state = S_REV_CHK;
            end
            S_DONE: begin
                if (!r_ovalid || m_axis_tready) begin
                    n_ovalid  = 1'b1;
                    n_ostatus = r_status;
                    n_ord     = r_rd;
                    n_olen    = r_count;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_func    <= n_func;
        r_pos     <= n_pos;
        r_val     <= n_val;
        r_idx     <= n_idx;
        r_wa      <= n_wa;
        r_hi      <= n_hi;
        r_hold    <= n_hold;
        r_status  <= n_status;
        r_rd      <= n_rd;
        r_ostatus <= n_ostatus;
        r_ord     <= n_ord;
        r_olen    <= n_olen;
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CAP_C)
        else $error("list length above capacity");

    a_accept_decode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> (r_state == S_DECODE))
        else $error("accepted item not decoded");

    a_append_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DECODE && r_func == F_APPEND && !full)
        |=> (r_count == $past(r_count) + CW'(1)))
        else $error("append did not grow the list");

    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovalid) |-> ($past(r_state) == S_DONE))
        else $error("result loaded outside the done state");

    a_write_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> (mem_wa < CAP_C))
        else $error("memory write beyond capacity");

endmodule

`default_nettype wire
